/* rtl/rotor_cipher_machine_assert.svh */
// Assertion macros shared by the queue and back-pipeline modules.
`ifndef ROTOR_CIPHER_MACHINE_ASSERT_SVH
`define ROTOR_CIPHER_MACHINE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define RCM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define RCM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define RCM_ASSERT_IMPL(lbl, ante, cons, msg)
`define RCM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* rtl/rcm_pkg.sv */
package rcm_pkg;

  typedef logic [25:0][4:0] tab_t;

  typedef enum logic [2:0] {
    REG_ROTOR_CHOICE     = 3'd0,
    REG_RING_SETTINGS    = 3'd1,
    REG_START_POSITIONS  = 3'd2,
    REG_REFLECTOR_CHOICE = 3'd3,
    REG_PLUG_PAIRS_LOW   = 3'd4,
    REG_PLUG_PAIRS_HIGH  = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic [8:0]  rotor_choice;
    logic [14:0] ring_settings;
    logic        reflector_choice;
    logic [59:0] plug_pairs_low;
    logic [39:0] plug_pairs_high;
  } rcm_cfg_t;

  localparam logic [7:0] CHAR_UA = 8'h41;
  localparam logic [7:0] CHAR_UZ = 8'h5A;
  localparam logic [7:0] CHAR_LA = 8'h61;
  localparam logic [7:0] CHAR_LZ = 8'h7A;

  function automatic tab_t to_tab(logic [207:0] s);
    tab_t t;
    for (int j = 0; j < 26; j++) begin
      t[j] = 5'(s[8*(25-j) +: 8] - CHAR_UA);
    end
    return t;
  endfunction

  function automatic tab_t inv_of(logic [207:0] s);
    tab_t t;
    logic [4:0] c;
    for (int j = 0; j < 26; j++) begin
      c = 5'(s[8*(25-j) +: 8] - CHAR_UA);
      t[c] = 5'(j);
    end
    return t;
  endfunction

  localparam logic [207:0] W_I   = "EKMFLGDQVZNTOWYHXUSPAIBRCJ";
  localparam logic [207:0] W_II  = "AJDKSIRUXBLHWTMCQGZNPYFVOE";
  localparam logic [207:0] W_III = "BDFHJLCPRTXVZNYEIWGAKMQOUS";
  localparam logic [207:0] W_IV  = "ESOVPZJAYQUWIGLNRKXBTMCDHF";
  localparam logic [207:0] W_V   = "VZBRGITYUPSDNHLXAWMCQJFEOK";
  localparam logic [207:0] W_B   = "YRUHQSLDPXNGOKMIEBFZCWVJAT";
  localparam logic [207:0] W_C   = "FVPJIAOYEDRZXWGCTKUQSBNMHL";

  localparam tab_t ROT_FWD [5] = '{to_tab(W_I), to_tab(W_II), to_tab(W_III),
                                   to_tab(W_IV), to_tab(W_V)};
  localparam tab_t ROT_BWD [5] = '{inv_of(W_I), inv_of(W_II), inv_of(W_III),
                                   inv_of(W_IV), inv_of(W_V)};
  localparam tab_t REFL [2] = '{to_tab(W_B), to_tab(W_C)};
  localparam logic [4:0] TURN [5] = '{5'd16, 5'd4, 5'd21, 5'd9, 5'd25};

  function automatic logic [4:0] mod26(logic [5:0] v);
    return (v >= 6'd26) ? 5'(v - 6'd26) : v[4:0];
  endfunction

  function automatic logic [2:0] type_of(logic [2:0] code);
    return (code > 3'd4) ? 3'd4 : code;
  endfunction

  function automatic logic [4:0] rot_fwd(logic [2:0] ty, logic [4:0] s, logic [4:0] x);
    logic [4:0] t;
    logic [4:0] w;
    t = mod26({1'b0, x} + {1'b0, s});
    w = ROT_FWD[ty][t];
    return mod26({1'b0, w} + 6'd26 - {1'b0, s});
  endfunction

  function automatic logic [4:0] rot_bwd(logic [2:0] ty, logic [4:0] s, logic [4:0] x);
    logic [4:0] t;
    logic [4:0] w;
    t = mod26({1'b0, x} + {1'b0, s});
    w = ROT_BWD[ty][t];
    return mod26({1'b0, w} + 6'd26 - {1'b0, s});
  endfunction

endpackage

/* rtl/rcm_fifo.sv */
module rcm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] rdata
);
  `include "rotor_cipher_machine_assert.svh"

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic do_push;
  logic do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      count <= count + CW'(do_push) - CW'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  `RCM_ASSERT_IMPL(a_count_range, 1'b1, count <= CW'(DEPTH), "queue count out of range")
  `RCM_ASSERT_NEXT(a_push_counts, do_push && !do_pop, count == $past(count) + CW'(1), "accepted item not counted")
  `RCM_ASSERT_NEXT(a_pop_counts, do_pop && !do_push, count == $past(count) - CW'(1), "taken item not removed")
endmodule

/* rtl/rcm_front.sv */
module rcm_front #(
  parameter int ROTOR_COUNT = 3
) (
  input  logic                   clk,
  input  logic                   rst,
  input  rcm_pkg::rcm_cfg_t      cfg,
  input  logic                   load,
  input  logic [14:0]            load_val,
  input  logic                   push,
  output logic                   full,
  input  logic [7:0]             in_byte,
  input  logic                   q_full,
  output logic                   q_push,
  output logic [14+5*ROTOR_COUNT-1:0] q_data
);
  import rcm_pkg::*;

  logic [ROTOR_COUNT-1:0][4:0] pos;
  logic [ROTOR_COUNT-1:0][4:0] pos_next;
  logic [ROTOR_COUNT-1:0][4:0] start;
  logic [ROTOR_COUNT-1:0][2:0] rtype;
  logic [ROTOR_COUNT-1:0] hit;
  logic [ROTOR_COUNT-1:0] adv;
  logic is_upper;
  logic is_lower;
  logic is_letter;
  logic [4:0] idx;

  for (genvar i = 0; i < ROTOR_COUNT; i++) begin : g_rot
    localparam int K = ROTOR_COUNT - 1 - i;
    if (K < 3) begin : g_field
      assign rtype[i] = type_of(cfg.rotor_choice[3*K +: 3]);
      assign start[i] = mod26({1'b0, load_val[5*K +: 5]});
    end else begin : g_zero
      assign rtype[i] = 3'd0;
      assign start[i] = 5'd0;
    end
    assign hit[i] = (pos[i] == TURN[rtype[i]]);
    if (i == ROTOR_COUNT - 1) begin : g_right
      assign adv[i] = 1'b1;
    end else if (i == 0) begin : g_left
      assign adv[i] = hit[i+1];
    end else begin : g_mid
      assign adv[i] = hit[i+1] || hit[i];
    end
    assign pos_next[i] = adv[i] ? ((pos[i] == 5'd25) ? 5'd0 : pos[i] + 5'd1) : pos[i];
  end

  assign is_upper  = (in_byte >= CHAR_UA) && (in_byte <= CHAR_UZ);
  assign is_lower  = (in_byte >= CHAR_LA) && (in_byte <= CHAR_LZ);
  assign is_letter = is_upper || is_lower;
  assign idx = is_upper ? 5'(in_byte - CHAR_UA) : (is_lower ? 5'(in_byte - CHAR_LA) : 5'd0);

  assign full   = q_full;
  assign q_push = push && !q_full;
  assign q_data = {in_byte, is_letter, idx, is_letter ? pos_next : pos};

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (load) begin
      pos <= start;
    end else if (q_push && is_letter) begin
      pos <= pos_next;
    end
  end
endmodule

/* rtl/rcm_back.sv */
module rcm_back #(
  parameter int ROTOR_COUNT = 3
) (
  input  logic                   clk,
  input  logic                   rst,
  input  rcm_pkg::rcm_cfg_t      cfg,
  input  logic                   q_empty,
  input  logic [14+5*ROTOR_COUNT-1:0] q_data,
  output logic                   q_pop,
  input  logic                   o_full,
  output logic                   o_push,
  output logic [8:0]             o_data
);
  import rcm_pkg::*;
  `include "rotor_cipher_machine_assert.svh"

  localparam int L = 2 * ROTOR_COUNT + 3;

  logic [ROTOR_COUNT-1:0][2:0] rtype;
  logic [ROTOR_COUNT-1:0][4:0] ring;
  logic [9:0][4:0] pa;
  logic [9:0][4:0] pb;
  logic [9:0] plug_on_next;
  logic [9:0] plug_on;

  logic vld [L];
  logic st_let [L];
  logic [7:0] st_byte [L];
  logic [4:0] st_x [L];
  logic [ROTOR_COUNT-1:0][4:0] st_sh [L];
  logic [4:0] nx_x [L];
  logic [ROTOR_COUNT-1:0][4:0] sh0;

  logic [7:0] q_byte;
  logic q_let;
  logic [4:0] q_idx;
  logic [ROTOR_COUNT-1:0][4:0] q_pos;
  logic adv;

  assign {q_byte, q_let, q_idx, q_pos} = q_data;

  for (genvar i = 0; i < ROTOR_COUNT; i++) begin : g_rot
    localparam int K = ROTOR_COUNT - 1 - i;
    if (K < 3) begin : g_field
      assign rtype[i] = type_of(cfg.rotor_choice[3*K +: 3]);
      assign ring[i]  = mod26({1'b0, cfg.ring_settings[5*K +: 5]});
    end else begin : g_zero
      assign rtype[i] = 3'd0;
      assign ring[i]  = 5'd0;
    end
    assign sh0[i] = mod26({1'b0, q_pos[i]} + 6'd26 - {1'b0, ring[i]});
  end

  for (genvar p = 0; p < 10; p++) begin : g_pair
    if (p < 6) begin : g_low
      assign pa[p] = cfg.plug_pairs_low[10*p +: 5];
      assign pb[p] = cfg.plug_pairs_low[10*p+5 +: 5];
    end else begin : g_high
      assign pa[p] = cfg.plug_pairs_high[10*(p-6) +: 5];
      assign pb[p] = cfg.plug_pairs_high[10*(p-6)+5 +: 5];
    end
  end

  // A pair is wired only when both letters are valid, distinct and still free.
  always_comb begin
    logic ok;
    for (int p = 0; p < 10; p++) begin
      ok = (pa[p] < 5'd26) && (pb[p] < 5'd26) && (pa[p] != pb[p]);
      for (int q = 0; q < p; q++) begin
        if (plug_on_next[q] && (pa[p] == pa[q] || pa[p] == pb[q] ||
                                pb[p] == pa[q] || pb[p] == pb[q])) begin
          ok = 1'b0;
        end
      end
      plug_on_next[p] = ok;
    end
  end

  always_ff @(posedge clk) begin
    plug_on <= plug_on_next;
  end

  function automatic logic [4:0] plug(logic [4:0] x, logic [9:0] en,
                                      logic [9:0][4:0] a, logic [9:0][4:0] b);
    logic [4:0] r;
    r = x;
    for (int p = 0; p < 10; p++) begin
      if (en[p] && a[p] == x) r = b[p];
      if (en[p] && b[p] == x) r = a[p];
    end
    return r;
  endfunction

  for (genvar k = 0; k < L; k++) begin : g_stage
    if (k == 0) begin : g_plug_in
      assign nx_x[k] = plug(q_idx, plug_on, pa, pb);
    end else if (k <= ROTOR_COUNT) begin : g_fwd
      localparam int R = ROTOR_COUNT - k;
      assign nx_x[k] = rot_fwd(rtype[R], st_sh[k-1][R], st_x[k-1]);
    end else if (k == ROTOR_COUNT + 1) begin : g_refl
      assign nx_x[k] = REFL[cfg.reflector_choice][st_x[k-1]];
    end else if (k <= 2 * ROTOR_COUNT + 1) begin : g_bwd
      localparam int R = k - ROTOR_COUNT - 2;
      assign nx_x[k] = rot_bwd(rtype[R], st_sh[k-1][R], st_x[k-1]);
    end else begin : g_plug_out
      assign nx_x[k] = plug(st_x[k-1], plug_on, pa, pb);
    end
  end

  assign adv    = !vld[L-1] || !o_full;
  assign q_pop  = adv && !q_empty;
  assign o_push = vld[L-1] && !o_full;
  assign o_data = {st_let[L-1] ? ({3'b000, st_x[L-1]} + CHAR_UA) : st_byte[L-1],
                   st_let[L-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < L; k++) vld[k] <= 1'b0;
    end else if (adv) begin
      vld[0] <= !q_empty;
      for (int k = 1; k < L; k++) vld[k] <= vld[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_byte[0] <= q_byte;
      st_let[0]  <= q_let;
      st_sh[0]   <= sh0;
      for (int k = 1; k < L; k++) begin
        st_byte[k] <= st_byte[k-1];
        st_let[k]  <= st_let[k-1];
        st_sh[k]   <= st_sh[k-1];
      end
      for (int k = 0; k < L; k++) st_x[k] <= nx_x[k];
    end
  end

  `RCM_ASSERT_NEXT(a_stall_hold, vld[L-1] && !adv, vld[L-1] && $stable(st_x[L-1]), "stalled result changed")
  `RCM_ASSERT_NEXT(a_bubble, adv && q_empty, !vld[0], "item invented from an empty queue")
  `RCM_ASSERT_IMPL(a_letter_range, vld[L-1] && st_let[L-1], st_x[L-1] < 5'd26, "letter index out of range")
endmodule

/* rtl/rotor_cipher_machine.sv */
// Rotor cipher machine: one ASCII byte per item, one item per clock sustained while the
// output is not held full. Letters are folded to upper case, step the rotors and are
// enciphered; other bytes pass unchanged. The front steps the rotor positions as it accepts
// an item, so items may follow back to back; the back is a pipeline of 2*ROTOR_COUNT+3
// substitution stages (plugboard, each rotor forward, reflector, each rotor backward,
// plugboard). Small queues on both sides of the back pipeline absorb stalls.
// Configuration must be written only while the block is idle; the block itself does not
// enforce this. Writing start_positions reloads the rotor positions at once.
module rotor_cipher_machine #(
  parameter int ROTOR_COUNT = 3
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [59:0] cfg_data,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        was_letter
);
  import rcm_pkg::*;

  localparam int EW = 14 + 5 * ROTOR_COUNT;

  rcm_cfg_t cfg;
  logic load;
  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;
  logic [EW-1:0] q_wdata;
  logic [EW-1:0] q_rdata;
  logic o_push;
  logic o_full;
  logic [8:0] o_wdata;
  logic [8:0] o_rdata;

  assign load = cfg_we && (cfg_index == REG_START_POSITIONS);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rotor_choice     <= 9'd10;
      cfg.ring_settings    <= '0;
      cfg.reflector_choice <= 1'b0;
      cfg.plug_pairs_low   <= '0;
      cfg.plug_pairs_high  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROTOR_CHOICE:     cfg.rotor_choice     <= cfg_data[8:0];
        REG_RING_SETTINGS:    cfg.ring_settings    <= cfg_data[14:0];
        REG_REFLECTOR_CHOICE: cfg.reflector_choice <= cfg_data[0];
        REG_PLUG_PAIRS_LOW:   cfg.plug_pairs_low   <= cfg_data[59:0];
        REG_PLUG_PAIRS_HIGH:  cfg.plug_pairs_high  <= cfg_data[39:0];
        default: ;
      endcase
    end
  end

  rcm_front #(.ROTOR_COUNT(ROTOR_COUNT)) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .load     (load),
    .load_val (cfg_data[14:0]),
    .push     (push),
    .full     (full),
    .in_byte  (in_byte),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_wdata)
  );

  rcm_fifo #(.WIDTH(EW), .DEPTH(4)) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .full  (q_full),
    .wdata (q_wdata),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_rdata)
  );

  rcm_back #(.ROTOR_COUNT(ROTOR_COUNT)) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_empty (q_empty),
    .q_data  (q_rdata),
    .q_pop   (q_pop),
    .o_full  (o_full),
    .o_push  (o_push),
    .o_data  (o_wdata)
  );

  rcm_fifo #(.WIDTH(9), .DEPTH(4)) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (o_push),
    .full  (o_full),
    .wdata (o_wdata),
    .pop   (pop),
    .empty (empty),
    .rdata (o_rdata)
  );

  assign out_byte   = o_rdata[8:1];
  assign was_letter = o_rdata[0];
endmodule
